// File: rtl/nwsa_pkg.sv
package nwsa_pkg;

    // Weight store geometry.
    localparam int MAX_WEIGHTS = 64;
    localparam int ADDR_W      = $clog2(MAX_WEIGHTS);

    // Depth of the result queue; also the number of results that may be in flight.
    localparam int RES_DEPTH   = 8;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);

    // Input operations.
    localparam logic OP_WRITE_WEIGHT = 1'b0;
    localparam logic OP_FEED         = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WEIGHT_COUNT    = 2'd0;
    localparam logic [1:0] CFG_BIAS            = 2'd1;
    localparam logic [1:0] CFG_ACTIVATION_MODE = 2'd2;

    // Activation functions.
    localparam logic [1:0] ACT_STEP     = 2'd0;
    localparam logic [1:0] ACT_SATLIN   = 2'd1;
    localparam logic [1:0] ACT_LOGISTIC = 2'd2;
    localparam logic [1:0] ACT_BIPOLAR  = 2'd3;

    // One in Q2.14.
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic              opcode;
        logic [5:0]        weight_index;
        logic signed [15:0] data_value;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] activation_out;
        logic               length_mismatch;
    } out_item_t;

    typedef logic [255:0][15:0] lut_t;

    // Logistic table over [-8, 8) in steps of 1/16, Q2.14, built at elaboration.
    // e^-k/16 is stepped in Q32, then 2^46 / (2^32 + e) is rounded by a
    // restoring division.
    function automatic lut_t build_logistic();
        lut_t        t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        logic [15:0] p;
        t = '0;
        for (int k = 0; k <= 128; k++)
        begin
            e = 64'd1 << 32;
            for (int j = 0; j < k; j++)
            begin
                e = (e * 64'd4034748383 + (64'd1 << 31)) >> 32;
            end
            den = (64'd1 << 32) + e;
            num = (64'd1 << 46) + (den >> 1);
            rem = '0;
            q   = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[b] = 1'b1;
                end
            end
            p = q[15:0];
            if (k < 128)
            begin
                t[128 + k] = p;
            end
            if (k > 0)
            begin
                t[128 - k] = 16'd16384 - p;
            end
        end
        return t;
    endfunction

    localparam lut_t LOGISTIC_LUT = build_logistic();

endpackage

// File: rtl/neuron_weighted_sum_activation_unit.sv
// Single neuron: weight-write beats store signed Q4.12 weights by slot, feed
// beats stream a vector whose elements are multiplied by the weight at their
// position and summed on top of the bias; the beat marked last yields one
// Q2.14 activation (step, saturated linear, logistic or bipolar sigmoid), or
// zero with length_mismatch set when the vector length differs from
// weight_count or weight_count exceeds 64. One input beat is taken every
// cycle while in_stall is low. The weights sit in a single-port synchronous
// RAM read once per feed beat, followed by a registered multiplier, the
// accumulator adder, the bias stage and two activation stages. Results queue
// in an eight-entry buffer; input stalls only while eight results are
// outstanding and not yet taken. Configuration is always ready and must only
// be written while the block is idle.
module neuron_weighted_sum_activation_unit
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  nwsa_pkg::in_item_t   in_data,

    output logic                 out_valid,
    input  logic                 out_stall,
    output nwsa_pkg::out_item_t  out_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // Configuration registers.
    logic [6:0]         weight_count_reg;
    logic signed [15:0] bias_reg;
    logic [1:0]         act_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_count_reg <= '0;
            bias_reg         <= '0;
            act_mode_reg     <= nwsa_pkg::ACT_BIPOLAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nwsa_pkg::CFG_WEIGHT_COUNT:    weight_count_reg <= cfg_data[6:0];
                nwsa_pkg::CFG_BIAS:            bias_reg         <= cfg_data;
                nwsa_pkg::CFG_ACTIVATION_MODE: act_mode_reg     <= cfg_data[1:0];
                default:                       ;
            endcase
        end
    end

    // Input handshake and credit count of results in flight or queued.
    logic                        in_accept;
    logic                        out_pop;
    logic [nwsa_pkg::RES_PTR_W:0] pending_reg;
    logic [nwsa_pkg::RES_PTR_W:0] pending_next;
    logic                        is_feed;
    logic                        starts_result;

    assign in_stall      = (pending_reg == (nwsa_pkg::RES_PTR_W + 1)'(nwsa_pkg::RES_DEPTH));
    assign in_accept     = in_valid && !in_stall;
    assign is_feed       = (in_data.opcode == nwsa_pkg::OP_FEED);
    assign starts_result = in_accept && is_feed && in_data.last;

    always_comb
    begin
        pending_next = pending_reg;
        if (starts_result && !out_pop)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!starts_result && out_pop)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Element position within the current vector, saturating at 127.
    logic [6:0] elem_count_reg;
    logic [6:0] elem_count_inc;
    logic       elem_in_range;

    assign elem_count_inc = (elem_count_reg == 7'd127) ? elem_count_reg : elem_count_reg + 7'd1;
    assign elem_in_range  = ({25'd0, elem_count_reg} < nwsa_pkg::MAX_WEIGHTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg <= '0;
        end
        else if (in_accept && is_feed)
        begin
            elem_count_reg <= in_data.last ? 7'd0 : elem_count_inc;
        end
    end

    // Weight RAM: written by weight beats, read once per feed beat. At most one beat
    // is taken per cycle, so a read always follows any earlier write.
    logic signed [15:0] weight_mem [nwsa_pkg::MAX_WEIGHTS];
    logic signed [15:0] weight_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept && !is_feed)
        begin
            weight_mem[in_data.weight_index[nwsa_pkg::ADDR_W-1:0]] <= in_data.data_value;
        end
        if (in_accept && is_feed)
        begin
            weight_rd_reg <= weight_mem[elem_count_reg[nwsa_pkg::ADDR_W-1:0]];
        end
    end

    // Stage 1: element and status aligned with the RAM read data.
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_in_range_reg;
    logic [6:0]         s1_count_reg;
    logic signed [15:0] s1_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept && is_feed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_feed)
        begin
            s1_last_reg     <= in_data.last;
            s1_in_range_reg <= elem_in_range;
            s1_count_reg    <= elem_count_inc;
            s1_data_reg     <= in_data.data_value;
        end
    end

    // Stage 2: product of element and weight, exact Q8.24.
    logic signed [15:0] s1_weight;
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [6:0]         s2_count_reg;
    logic signed [31:0] s2_prod_reg;

    assign s1_weight = s1_in_range_reg ? weight_rd_reg : 16'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg  <= s1_last_reg;
        s2_count_reg <= s1_count_reg;
        s2_prod_reg  <= s1_data_reg * s1_weight;
    end

    // Stage 3: saturating accumulation; the accumulator clears after a last element.
    logic signed [39:0] acc_reg;
    logic signed [39:0] acc_next;
    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic               s3_valid_reg;
    logic [6:0]         s3_count_reg;
    logic signed [39:0] s3_acc_reg;

    assign acc_sum = {acc_reg[39], acc_reg} + {{9{s2_prod_reg[31]}}, s2_prod_reg};

    always_comb
    begin
        if (acc_sum[40] != acc_sum[39])
        begin
            acc_sat = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[39:0];
        end
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = s2_last_reg ? 40'sd0 : acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_count_reg <= s2_count_reg;
        s3_acc_reg   <= acc_sat;
    end

    // Stage 4: bias added with saturation, length check.
    logic signed [40:0] bias_sum;
    logic signed [39:0] bias_sat;
    logic               mismatch;
    logic               s4_valid_reg;
    logic               s4_mismatch_reg;
    logic signed [39:0] s4_sum_reg;

    assign bias_sum = {s3_acc_reg[39], s3_acc_reg}
                    + {{13{bias_reg[15]}}, bias_reg, 12'd0};
    assign mismatch = (s3_count_reg != weight_count_reg)
                   || ({25'd0, weight_count_reg} > nwsa_pkg::MAX_WEIGHTS);

    always_comb
    begin
        if (bias_sum[40] != bias_sum[39])
        begin
            bias_sat = bias_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end
        else
        begin
            bias_sat = bias_sum[39:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_mismatch_reg <= mismatch;
        s4_sum_reg      <= bias_sat;
    end

    // Stage 5: step and linear outputs, table index of the clamped sum.
    logic               ge_one;
    logic               below_range;
    logic               above_range;
    logic signed [15:0] simple_act;
    logic [7:0]         lut_index;
    logic               s5_valid_reg;
    logic               s5_mismatch_reg;
    logic [1:0]         s5_mode_reg;
    logic signed [15:0] s5_simple_reg;
    logic [7:0]         s5_index_reg;

    assign ge_one      = !s4_sum_reg[39] && (s4_sum_reg[38:24] != 15'd0);
    assign below_range = s4_sum_reg[39] && (s4_sum_reg[38:27] != {12{1'b1}});
    assign above_range = !s4_sum_reg[39] && (s4_sum_reg[38:27] != 12'd0);

    always_comb
    begin
        if (ge_one)
        begin
            simple_act = nwsa_pkg::ONE_Q14;
        end
        else if (s4_sum_reg[39] || (act_mode_reg == nwsa_pkg::ACT_STEP))
        begin
            simple_act = 16'sd0;
        end
        else
        begin
            simple_act = {2'b00, s4_sum_reg[23:10]};
        end

        if (below_range)
        begin
            lut_index = 8'd0;
        end
        else if (above_range)
        begin
            lut_index = 8'd255;
        end
        else
        begin
            lut_index = {~s4_sum_reg[27], s4_sum_reg[26:20]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_mismatch_reg <= s4_mismatch_reg;
        s5_mode_reg     <= act_mode_reg;
        s5_simple_reg   <= simple_act;
        s5_index_reg    <= lut_index;
    end

    // Final selection: table lookup for the sigmoids.
    logic [15:0]         lut_val;
    logic signed [16:0]  bipolar_val;
    nwsa_pkg::out_item_t result;

    assign lut_val     = nwsa_pkg::LOGISTIC_LUT[s5_index_reg];
    assign bipolar_val = {lut_val, 1'b0} - 17'sd16384;

    always_comb
    begin
        result.length_mismatch = s5_mismatch_reg;
        if (s5_mismatch_reg)
        begin
            result.activation_out = 16'sd0;
        end
        else
        begin
            case (s5_mode_reg)
                nwsa_pkg::ACT_LOGISTIC: result.activation_out = lut_val;
                nwsa_pkg::ACT_BIPOLAR:  result.activation_out = bipolar_val[15:0];
                default:                result.activation_out = s5_simple_reg;
            endcase
        end
    end

    // Result queue; the credit count keeps it from overflowing.
    nwsa_pkg::out_item_t          res_mem [nwsa_pkg::RES_DEPTH];
    logic [nwsa_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [nwsa_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [nwsa_pkg::RES_PTR_W:0]   fill_reg;

    assign out_valid = (fill_reg != '0);
    assign out_pop   = out_valid && !out_stall;
    assign out_data  = res_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (s5_valid_reg)
        begin
            res_mem[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (s5_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (s5_valid_reg && !out_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (!s5_valid_reg && out_pop)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    import nwsa_pkg::*;

    // Q.24 thresholds used by the activation predictor.
    localparam longint ONE_Q24   = 64'sd16777216;
    localparam longint SIG_RANGE = 64'sd134217728;
    localparam longint ACC_MAX   = 64'sd549755813887;
    localparam longint ACC_MIN   = -64'sd549755813888;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Beats waiting to be driven and results waiting to be seen.
    in_item_t  pending_beats[$];
    out_item_t expected_activations[$];
    out_item_t expected_head;

    int beats_queued   = 0;
    int beats_accepted = 0;
    int error_count    = 0;
    bit in_taken       = 1'b0;
    bit idle_on        = 1'b1;
    int in_gap         = 0;
    int out_hold       = 0;

    // Predictor copy of the neuron state and its settings.
    logic signed [15:0] weight_mirror [MAX_WEIGHTS];
    longint             sum_mirror    = 0;
    int                 count_mirror  = 0;
    int                 len_setting   = 0;
    logic signed [15:0] bias_setting  = '0;
    logic [1:0]         mode_setting  = ACT_BIPOLAR;

    logic [1:0] mode_cycle [4] = '{ACT_STEP, ACT_SATLIN, ACT_LOGISTIC, ACT_BIPOLAR};

    neuron_weighted_sum_activation_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("FAIL neuron_weighted_sum_activation_unit");
        $finish;
    end

    function automatic longint sat40(longint v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    // logistic(k/16) in Q2.14, with e^-k/16 stepped in Q32 and the quotient rounded.
    function automatic int logistic_point(int k);
        longint unsigned e;
        longint unsigned den;
        e = 64'd1 << 32;
        for (int j = 0; j < k; j++)
        begin
            e = (e * 64'd4034748383 + (64'd1 << 31)) >> 32;
        end
        den = (64'd1 << 32) + e;
        return int'(((64'd1 << 46) + den / 2) / den);
    endfunction

    function automatic logic [15:0] activate_sum(longint s);
        longint clamped;
        int     idx;
        int     lvl;
        case (mode_setting)
            ACT_STEP:
            begin
                return (s >= ONE_Q24) ? ONE_Q14 : 16'd0;
            end
            ACT_SATLIN:
            begin
                if (s >= ONE_Q24)
                    return ONE_Q14;
                if (s < 0)
                    return 16'd0;
                return 16'(s >>> 10);
            end
            default:
            begin
            end
        endcase
        // Both sigmoids index the table over the sum clamped to [-8, 8).
        clamped = s;
        if (clamped < -SIG_RANGE)
            clamped = -SIG_RANGE;
        if (clamped > SIG_RANGE - 1)
            clamped = SIG_RANGE - 1;
        idx = int'((clamped + SIG_RANGE) >>> 20);
        lvl = (idx >= 128) ? logistic_point(idx - 128) : 16384 - logistic_point(128 - idx);
        if (mode_setting == ACT_LOGISTIC)
            return 16'(lvl);
        return 16'(2 * lvl - 16384);
    endfunction

    // Advance the predicted neuron by one accepted beat.
    function automatic void neuron_beat(in_item_t beat);
        longint    w;
        out_item_t res;
        bit        bad_len;
        if (beat.opcode == OP_WRITE_WEIGHT)
        begin
            weight_mirror[beat.weight_index] = beat.data_value;
            return;
        end
        w = (count_mirror < MAX_WEIGHTS) ? longint'(weight_mirror[count_mirror]) : 0;
        sum_mirror = sat40(sum_mirror + longint'($signed(beat.data_value)) * w);
        if (count_mirror < 127)
            count_mirror++;
        if (!beat.last)
            return;
        bad_len = (count_mirror != len_setting) || (len_setting > MAX_WEIGHTS);
        res.length_mismatch = bad_len;
        if (bad_len)
            res.activation_out = '0;
        else
            res.activation_out = activate_sum(sat40(sum_mirror + longint'(bias_setting) * 4096));
        expected_activations.push_back(res);
        sum_mirror   = 0;
        count_mirror = 0;
    endfunction

    // Input side: note taken beats and feed them to the predictor.
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            neuron_beat(in_data);
            beats_accepted++;
        end
    end

    // Input driver: present the next pending beat, with random gaps between beats.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_beats.pop_front();
                if (idle_on && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 16);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall in random bursts.
    always @(negedge clk)
    begin
        if (out_hold > 0)
            out_hold--;
        else if (idle_on && $urandom_range(0, 5) == 0)
            out_hold = $urandom_range(1, 16);
        out_stall <= (out_hold > 0);
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_activations.size() == 0)
            begin
                $error("unexpected result beat: activation_out=%0d length_mismatch=%0b",
                       $signed(out_data.activation_out), out_data.length_mismatch);
                error_count++;
            end
            else
            begin
                expected_head = expected_activations.pop_front();
                if (out_data.activation_out !== expected_head.activation_out)
                begin
                    $error("activation_out: expected %0d, got %0d",
                           $signed(expected_head.activation_out),
                           $signed(out_data.activation_out));
                    error_count++;
                end
                if (out_data.length_mismatch !== expected_head.length_mismatch)
                begin
                    $error("length_mismatch: expected %0b, got %0b",
                           expected_head.length_mismatch, out_data.length_mismatch);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [15:0] rand_q12();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 16'($urandom_range(0, 8192)) - 16'd4096;
        if (pick < 17)
            return 16'($urandom_range(0, 32767)) - 16'd16384;
        if (pick == 17)
            return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return 16'($urandom);
    endfunction

    task automatic queue_beat(logic op, logic [5:0] slot, logic [15:0] value, logic last);
        in_item_t b;
        b.opcode       = op;
        b.weight_index = slot;
        b.data_value   = value;
        b.last         = last;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // The last bit of a weight write and the slot of a feed are don't-cares; randomize them.
    task automatic queue_weight(logic [5:0] slot, logic [15:0] value);
        queue_beat(OP_WRITE_WEIGHT, slot, value, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_feed(logic [15:0] value, logic last);
        queue_beat(OP_FEED, 6'($urandom), value, last);
    endtask

    // One vector of random elements, with an occasional weight write mixed in.
    task automatic queue_vector(int len);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_weight(6'($urandom), rand_q12());
            queue_feed(rand_q12(), k == len - 1);
        end
    endtask

    // Mostly vectors of the configured length, some of wrong length, some lone writes.
    task automatic queue_random_unit(int count);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            queue_weight(6'($urandom), rand_q12());
        else if (pick < 5 || count == 0)
            queue_vector($urandom_range(1, count + 3));
        else if (pick == 5 && $urandom_range(0, 7) == 0)
            queue_vector($urandom_range(MAX_WEIGHTS + 1, 140));
        else
            queue_vector(count);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_WEIGHT_COUNT:    len_setting  = int'(value[6:0]);
            CFG_BIAS:            bias_setting = value;
            CFG_ACTIVATION_MODE: mode_setting = value[1:0];
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int count, logic [15:0] bias, logic [1:0] mode);
        cfg_write(CFG_WEIGHT_COUNT, 16'(count));
        cfg_write(CFG_BIAS, bias);
        cfg_write(CFG_ACTIVATION_MODE, 16'(mode));
    endtask

    // Wait until every beat is taken and every result seen, then let the pipeline settle.
    task automatic wait_idle();
        while (beats_accepted != beats_queued || expected_activations.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int count;
        int pick;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load every slot so that no vector ever reads an unwritten weight.
        for (int i = 0; i < MAX_WEIGHTS; i++)
            queue_weight(6'(i), rand_q12());
        queue_weight(6'd0, 16'h1000);
        queue_weight(6'd1, 16'h1000);
        // Settings after reset: a weight count of zero makes every vector a mismatch.
        queue_feed(16'h1000, 1'b1);
        wait_idle();

        // Step: exactly one fires, just below one does not; field extremes; short vector;
        // a weight replaced in the middle of a vector.
        set_config(2, 16'h0000, ACT_STEP);
        queue_feed(16'h1000, 1'b0);
        queue_feed(16'h0000, 1'b1);
        queue_feed(16'h0FFF, 1'b0);
        queue_feed(16'h0000, 1'b1);
        queue_feed(16'h7FFF, 1'b0);
        queue_feed(16'h8000, 1'b1);
        queue_feed(16'h1000, 1'b1);
        queue_feed(16'h1000, 1'b0);
        queue_weight(6'd1, 16'h8000);
        queue_feed(16'h7FFF, 1'b1);
        wait_idle();

        // Saturated linear: inside the ramp, below zero, and at one.
        set_config(2, 16'h0800, ACT_SATLIN);
        queue_feed(16'h0000, 1'b0);
        queue_feed(16'h0000, 1'b1);
        queue_feed(16'hF000, 1'b0);
        queue_feed(16'h0000, 1'b1);
        queue_feed(16'h0800, 1'b0);
        queue_feed(16'h0000, 1'b1);
        wait_idle();

        // Sigmoids at both ends of the clamp and at the center.
        set_config(1, 16'h7FFF, ACT_LOGISTIC);
        queue_feed(16'h7FFF, 1'b1);
        wait_idle();
        set_config(1, 16'h8000, ACT_LOGISTIC);
        queue_feed(16'h8000, 1'b1);
        wait_idle();
        set_config(1, 16'h0000, ACT_BIPOLAR);
        queue_feed(16'h0000, 1'b1);
        queue_feed(16'h7FFF, 1'b1);
        queue_feed(16'h8000, 1'b1);
        wait_idle();

        // Random phases, each with its own settings; the last ones run without idling.
        for (int phase = 0; phase < 15; phase++)
        begin
            idle_on = (phase < 12);
            pick = $urandom_range(0, 9);
            if (phase == 0)
                count = MAX_WEIGHTS;
            else if (phase == 1 || pick < 6)
                count = $urandom_range(1, 8);
            else if (pick == 6)
                count = 0;
            else if (pick == 7)
                count = MAX_WEIGHTS;
            else
                count = $urandom_range(1, MAX_WEIGHTS);
            if (phase == 0)
                set_config(count, 16'h7FFF, mode_cycle[phase % 4]);
            else if (phase == 1)
                set_config(count, 16'h8000, mode_cycle[phase % 4]);
            else
                set_config(count, rand_q12(), mode_cycle[$urandom_range(0, 3)]);
            // One vector long enough to saturate the element count.
            if (phase == 3)
                queue_vector(130);
            pick = beats_queued + 80;
            while (beats_queued < pick)
                queue_random_unit(count);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS neuron_weighted_sum_activation_unit");
        else
            $display("FAIL neuron_weighted_sum_activation_unit");
        $finish;
    end

endmodule

// File: files.f
rtl/nwsa_pkg.sv
rtl/neuron_weighted_sum_activation_unit.sv
sim/tb_top.sv
